// ===== src/timer_queue_scheduler_defines.svh =====
// Assertion macros shared by the timer queue RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef TIMER_QUEUE_SCHEDULER_DEFINES_SVH
`define TIMER_QUEUE_SCHEDULER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TQS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define TQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tqs_pkg.sv =====
// Shared types and constants of the timer queue scheduler.
// No dependencies.
package tqs_pkg;

    localparam int MAX_TIMERS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(MAX_TIMERS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int ID_W        = 31;
    localparam int HANDLE_W    = 16;
    localparam int DELAY_W     = 32;
    localparam int TIME_W      = 48;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_TICK     = 2'd2,
        OP_STOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_SCHEDULED = 2'd0,
        KIND_REFUSED   = 2'd1,
        KIND_EXPIRED   = 2'd2,
        KIND_CANCELED  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_WRITE,
        CMD_CANCEL,
        CMD_CLEAR,
        CMD_MARK,
        CMD_FIRE
    } t_cmd_op;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cmd_op                  op;
        logic [IDX_W-1:0]         index;
        logic [ID_W-1:0]          id;
        logic [HANDLE_W-1:0]      handle;
        logic [TIME_W-1:0]        deadline;
        logic [DELAY_W-1:0]       interval;
        logic                     rpt;
        logic [TIME_W-1:0]        now;
    } t_cmd;

    // best due timer so far, handed from cell to cell
    typedef struct packed {
        logic                     valid;
        logic [TIME_W-1:0]        deadline;
        logic [ID_W-1:0]          id;
        logic [HANDLE_W-1:0]      handle;
        logic [IDX_W-1:0]         index;
    } t_carry;

endpackage

// ===== src/tqs_if.sv =====
// Request and response channel interfaces of the timer queue scheduler.
// Depends on tqs_pkg.
interface tqs_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       operation;
    logic [tqs_pkg::HANDLE_W-1:0]     owner_handle;
    logic [tqs_pkg::DELAY_W-1:0]      delay_ticks;
    logic                             repeating;
    logic [tqs_pkg::ID_W-1:0]         target_id;

    modport source (output valid, operation, owner_handle, delay_ticks, repeating, target_id,
                    input ready);
    modport sink   (input valid, operation, owner_handle, delay_ticks, repeating, target_id,
                    output ready);
endinterface

interface tqs_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       kind;
    logic [tqs_pkg::ID_W-1:0]         result_id;
    logic [tqs_pkg::HANDLE_W-1:0]     result_handle;
    logic                             last;

    modport source (output valid, kind, result_id, result_handle, last, input ready);
    modport sink   (input valid, kind, result_id, result_handle, last, output ready);
endinterface

// ===== src/tqs_cell.sv =====
// One timer entry of the queue plus one stage of the earliest-due compare chain.
// Depends on tqs_pkg.
module tqs_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tqs_pkg::IDX_W-1:0]   i_index,
    input  tqs_pkg::t_cmd               i_cmd,
    input  tqs_pkg::t_carry             i_carry,
    output tqs_pkg::t_carry             o_carry,
    output logic                        o_valid
);

    logic                            r_valid;
    logic                            r_due;
    logic [tqs_pkg::ID_W-1:0]        r_id;
    logic [tqs_pkg::HANDLE_W-1:0]    r_handle;
    logic [tqs_pkg::TIME_W-1:0]      r_deadline;
    logic [tqs_pkg::DELAY_W-1:0]     r_interval;
    logic                            r_repeat;
    tqs_pkg::t_carry                 r_carry;
    tqs_pkg::t_carry                 n_carry;
    logic                            w_mine;
    logic                            w_own_wins;

    assign w_mine = (i_cmd.index == i_index);

    // on a full tie the incoming entry has the lower index and keeps the slot
    assign w_own_wins = r_due && (!i_carry.valid || (r_deadline < i_carry.deadline) ||
                        ((r_deadline == i_carry.deadline) && (r_id < i_carry.id)));

    always_comb begin
        n_carry = i_carry;
        if (w_own_wins) begin
            n_carry.valid    = 1'b1;
            n_carry.deadline = r_deadline;
            n_carry.id       = r_id;
            n_carry.handle   = r_handle;
            n_carry.index    = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_due   <= 1'b0;
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
            case (i_cmd.op)
                tqs_pkg::CMD_WRITE: begin
                    if (w_mine) begin
                        r_valid    <= 1'b1;
                        r_due      <= 1'b0;
                        r_id       <= i_cmd.id;
                        r_handle   <= i_cmd.handle;
                        r_deadline <= i_cmd.deadline;
                        r_interval <= i_cmd.interval;
                        r_repeat   <= i_cmd.rpt;
                    end
                end
                tqs_pkg::CMD_CANCEL: begin
                    if (r_valid && (r_id == i_cmd.id)) begin
                        r_valid <= 1'b0;
                        r_due   <= 1'b0;
                    end
                end
                tqs_pkg::CMD_CLEAR: begin
                    r_valid <= 1'b0;
                    r_due   <= 1'b0;
                end
                tqs_pkg::CMD_MARK: begin
                    r_due <= r_valid && (r_deadline <= i_cmd.now);
                end
                tqs_pkg::CMD_FIRE: begin
                    if (w_mine) begin
                        r_due <= 1'b0;
                        if (r_repeat) begin
                            r_deadline <= r_deadline + tqs_pkg::TIME_W'(r_interval);
                        end else begin
                            r_valid <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_carry = r_carry;
    assign o_valid = r_valid;

endmodule

// ===== src/timer_queue_scheduler.sv =====
// Schedule and cancel answer in the cycle after the request is taken; a stop gives no result.
// A tick marks the due timers and walks the compare chain, then fires each expired timer and
// walks the chain again, and decides once more before the final result (none if none expired).
// One request at a time; the next request is taken once the last result is handed off.
// Synchronous active-low reset: all timers free, time 0, next id 0, running.
// Depends on tqs_pkg, tqs_if, tqs_cell and timer_queue_scheduler_defines.svh.
`include "timer_queue_scheduler_defines.svh"

module timer_queue_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tqs_req_if.sink    i_req,
    tqs_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK,
        S_SCAN,
        S_DECIDE
    } t_state;

    localparam int N = tqs_pkg::MAX_TIMERS;
    localparam logic [tqs_pkg::CNT_W-1:0] CNT_MAX = tqs_pkg::CNT_W'(tqs_pkg::MAX_RESULTS);

    t_state                              r_state, n_state;
    logic [tqs_pkg::TIME_W-1:0]          r_time, n_time;
    logic [tqs_pkg::ID_W-1:0]            r_next_id, n_next_id;
    logic                                r_running, n_running;
    logic [tqs_pkg::IDX_W-1:0]           r_scan, n_scan;
    logic [tqs_pkg::CNT_W-1:0]           r_cnt, n_cnt;
    logic                                r_has_pend, n_has_pend;
    logic [tqs_pkg::ID_W-1:0]            r_pend_id, n_pend_id;
    logic [tqs_pkg::HANDLE_W-1:0]        r_pend_handle, n_pend_handle;
    logic                                r_out_valid, n_out_valid;
    tqs_pkg::t_kind                      r_out_kind, n_out_kind;
    logic [tqs_pkg::ID_W-1:0]            r_out_id, n_out_id;
    logic [tqs_pkg::HANDLE_W-1:0]        r_out_handle, n_out_handle;
    logic                                r_out_last, n_out_last;

    tqs_pkg::t_cmd                       w_cmd;
    tqs_pkg::t_carry                     w_carry [0:N];
    logic [N-1:0]                        w_valid;
    logic [tqs_pkg::IDX_W-1:0]           w_free;
    logic                                w_full;
    logic                                w_accept;
    logic                                w_out_free;
    logic                                w_found;
    logic                                w_fire;
    logic                                w_stop;

    assign w_carry[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        tqs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (tqs_pkg::IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .o_valid (w_valid[g])
        );
    end

    // lowest free entry
    always_comb begin
        w_free = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!w_valid[i]) begin
                w_free = tqs_pkg::IDX_W'(i);
            end
        end
    end

    assign w_full     = &w_valid;
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_stop     = w_accept && (i_req.operation == tqs_pkg::OP_STOP);
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_found    = w_carry[N].valid && (r_cnt != CNT_MAX);
    assign w_fire     = (r_state == S_DECIDE) && w_found && (!r_has_pend || w_out_free);

    always_comb begin
        n_state       = r_state;
        n_time        = r_time;
        n_next_id     = r_next_id;
        n_running     = r_running;
        n_scan        = r_scan;
        n_cnt         = r_cnt;
        n_has_pend    = r_has_pend;
        n_pend_id     = r_pend_id;
        n_pend_handle = r_pend_handle;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_kind    = r_out_kind;
        n_out_id      = r_out_id;
        n_out_handle  = r_out_handle;
        n_out_last    = r_out_last;
        w_cmd         = '0;
        w_cmd.op      = tqs_pkg::CMD_NOP;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.operation)
                        tqs_pkg::OP_SCHEDULE: begin
                            n_out_valid  = 1'b1;
                            n_out_handle = '0;
                            n_out_last   = 1'b1;
                            if (!r_running || w_full) begin
                                n_out_kind = tqs_pkg::KIND_REFUSED;
                                n_out_id   = '0;
                            end else begin
                                w_cmd.op       = tqs_pkg::CMD_WRITE;
                                w_cmd.index    = w_free;
                                w_cmd.id       = r_next_id;
                                w_cmd.handle   = i_req.owner_handle;
                                w_cmd.deadline = r_time + tqs_pkg::TIME_W'(i_req.delay_ticks);
                                w_cmd.interval = i_req.delay_ticks;
                                w_cmd.rpt      = i_req.repeating;
                                n_out_kind     = tqs_pkg::KIND_SCHEDULED;
                                n_out_id       = r_next_id;
                                n_next_id      = r_next_id + 1'b1;
                            end
                        end
                        tqs_pkg::OP_CANCEL: begin
                            w_cmd.op     = tqs_pkg::CMD_CANCEL;
                            w_cmd.id     = i_req.target_id;
                            n_out_valid  = 1'b1;
                            n_out_kind   = tqs_pkg::KIND_CANCELED;
                            n_out_id     = i_req.target_id;
                            n_out_handle = '0;
                            n_out_last   = 1'b1;
                        end
                        tqs_pkg::OP_TICK: begin
                            n_time  = r_time + 1'b1;
                            n_state = S_MARK;
                        end
                        tqs_pkg::OP_STOP: begin
                            w_cmd.op  = tqs_pkg::CMD_CLEAR;
                            n_running = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MARK: begin
                w_cmd.op   = tqs_pkg::CMD_MARK;
                w_cmd.now  = r_time;
                n_cnt      = '0;
                n_has_pend = 1'b0;
                n_scan     = '0;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                // wait until the chain output reflects every cell
                n_scan = r_scan + 1'b1;
                if (r_scan == tqs_pkg::IDX_W'(N - 1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_found) begin
                    if (w_fire) begin
                        if (r_has_pend) begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = tqs_pkg::KIND_EXPIRED;
                            n_out_id     = r_pend_id;
                            n_out_handle = r_pend_handle;
                            n_out_last   = 1'b0;
                        end
                        w_cmd.op      = tqs_pkg::CMD_FIRE;
                        w_cmd.index   = w_carry[N].index;
                        n_pend_id     = w_carry[N].id;
                        n_pend_handle = w_carry[N].handle;
                        n_has_pend    = 1'b1;
                        n_cnt         = r_cnt + 1'b1;
                        n_scan        = '0;
                        n_state       = S_SCAN;
                    end
                end else if (!r_has_pend) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = tqs_pkg::KIND_EXPIRED;
                    n_out_id     = r_pend_id;
                    n_out_handle = r_pend_handle;
                    n_out_last   = 1'b1;
                    n_has_pend   = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_next_id   <= '0;
            r_running   <= 1'b1;
            r_scan      <= '0;
            r_cnt       <= '0;
            r_has_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_next_id   <= n_next_id;
            r_running   <= n_running;
            r_scan      <= n_scan;
            r_cnt       <= n_cnt;
            r_has_pend  <= n_has_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_id     <= n_pend_id;
        r_pend_handle <= n_pend_handle;
        r_out_kind    <= n_out_kind;
        r_out_id      <= n_out_id;
        r_out_handle  <= n_out_handle;
        r_out_last    <= n_out_last;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.kind          = r_out_kind;
    assign o_rsp.result_id     = r_out_id;
    assign o_rsp.result_handle = r_out_handle;
    assign o_rsp.last          = r_out_last;

    `TQS_ASSERT_NOW(a_fire_live, w_fire, w_valid[w_carry[N].index], "fired a free entry")
    `TQS_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_MAX, "too many expiries")
    `TQS_ASSERT_NEXT(a_stop_clears, w_stop, !r_running && (w_valid == '0), "stop left timers")
    `TQS_ASSERT_NOW(a_sched_running, w_cmd.op == tqs_pkg::CMD_WRITE, r_running && !w_full, "bad write")

endmodule

// ===== tb/tb_top.sv =====
// Testbench for timer_queue_scheduler: drives schedule, cancel, tick and stop requests
// and checks every result against an in-bench timer queue predictor.
// Depends on tqs_pkg, tqs_if and the timer_queue_scheduler RTL.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        tqs_pkg::t_kind                kind;
        logic [tqs_pkg::ID_W-1:0]      id;
        logic [tqs_pkg::HANDLE_W-1:0]  handle;
        logic                          last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    tqs_req_if req_ch ();
    tqs_rsp_if rsp_ch ();

    timer_queue_scheduler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // predictor state
    bit                            tm_valid    [tqs_pkg::MAX_TIMERS];
    logic [tqs_pkg::ID_W-1:0]      tm_id       [tqs_pkg::MAX_TIMERS];
    logic [tqs_pkg::HANDLE_W-1:0]  tm_handle   [tqs_pkg::MAX_TIMERS];
    logic [tqs_pkg::TIME_W-1:0]    tm_deadline [tqs_pkg::MAX_TIMERS];
    logic [tqs_pkg::DELAY_W-1:0]   tm_interval [tqs_pkg::MAX_TIMERS];
    bit                            tm_repeat   [tqs_pkg::MAX_TIMERS];
    logic [tqs_pkg::TIME_W-1:0]    now_ticks;
    logic [tqs_pkg::ID_W-1:0]      next_id;
    bit                            running;

    t_result pending_results[$];
    int      mismatches;
    int      results_seen;
    int      expired_seen;
    int      requests_sent;
    int      cycle_count;
    bit      rsp_stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit fires_before(int a, int b);
        if (tm_deadline[a] != tm_deadline[b]) return tm_deadline[a] < tm_deadline[b];
        if (tm_id[a] != tm_id[b]) return tm_id[a] < tm_id[b];
        return a < b;
    endfunction

    function automatic void predict_request(tqs_pkg::t_op op,
                                            logic [tqs_pkg::HANDLE_W-1:0] handle,
                                            logic [tqs_pkg::DELAY_W-1:0] delay, bit rpt,
                                            logic [tqs_pkg::ID_W-1:0] target);
        int slot;
        int best;
        int fired;
        bit due [tqs_pkg::MAX_TIMERS];
        t_result r;
        slot = -1;
        fired = 0;
        case (op)
            tqs_pkg::OP_SCHEDULE: begin
                for (int i = tqs_pkg::MAX_TIMERS - 1; i >= 0; i--) if (!tm_valid[i]) slot = i;
                if (!running || slot < 0) begin
                    pending_results.push_back('{tqs_pkg::KIND_REFUSED, '0, '0, 1'b1});
                end else begin
                    tm_valid[slot]    = 1'b1;
                    tm_id[slot]       = next_id;
                    tm_handle[slot]   = handle;
                    tm_deadline[slot] = now_ticks + tqs_pkg::TIME_W'(delay);
                    tm_interval[slot] = delay;
                    tm_repeat[slot]   = rpt;
                    pending_results.push_back('{tqs_pkg::KIND_SCHEDULED, next_id, '0, 1'b1});
                    next_id = next_id + 1'b1;
                end
            end
            tqs_pkg::OP_CANCEL: begin
                for (int i = 0; i < tqs_pkg::MAX_TIMERS; i++)
                    if (tm_valid[i] && tm_id[i] == target) tm_valid[i] = 1'b0;
                pending_results.push_back('{tqs_pkg::KIND_CANCELED, target, '0, 1'b1});
            end
            tqs_pkg::OP_TICK: begin
                now_ticks = now_ticks + 1'b1;
                for (int i = 0; i < tqs_pkg::MAX_TIMERS; i++)
                    due[i] = tm_valid[i] && tm_deadline[i] <= now_ticks;
                while (fired < tqs_pkg::MAX_RESULTS) begin
                    best = -1;
                    for (int i = 0; i < tqs_pkg::MAX_TIMERS; i++)
                        if (due[i] && (best < 0 || fires_before(i, best))) best = i;
                    if (best < 0) break;
                    due[best] = 1'b0;
                    pending_results.push_back('{tqs_pkg::KIND_EXPIRED, tm_id[best],
                                                tm_handle[best], 1'b0});
                    fired++;
                    // re-arm repeating timers, free one-shots
                    if (tm_repeat[best])
                        tm_deadline[best] = tm_deadline[best] +
                                            tqs_pkg::TIME_W'(tm_interval[best]);
                    else
                        tm_valid[best] = 1'b0;
                end
                if (fired > 0) begin
                    r = pending_results.pop_back();
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
            end
            default: begin
                for (int i = 0; i < tqs_pkg::MAX_TIMERS; i++) tm_valid[i] = 1'b0;
                running = 1'b0;
            end
        endcase
    endfunction

    // response checker, with its own stall pattern
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            results_seen <= results_seen + 1;
            if (rsp_ch.kind == tqs_pkg::KIND_EXPIRED) expired_seen <= expired_seen + 1;
            if (pending_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("Unexpected result kind=%0d id=%0d", rsp_ch.kind,
                             rsp_ch.result_id);
            end else begin
                exp_r = pending_results.pop_front();
                if (rsp_ch.kind !== exp_r.kind || rsp_ch.result_id !== exp_r.id ||
                    rsp_ch.result_handle !== exp_r.handle || rsp_ch.last !== exp_r.last) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected kind=%0d id=%0d handle=%0d last=%0d,",
                                  " got kind=%0d id=%0d handle=%0d last=%0d"},
                                 exp_r.kind, exp_r.id, exp_r.handle, exp_r.last,
                                 rsp_ch.kind, rsp_ch.result_id, rsp_ch.result_handle,
                                 rsp_ch.last);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (cycle_count % 300 < 100) rsp_ch.ready <= 1'b1;
        else if (rsp_stall_mode) rsp_ch.ready <= (cycle_count % 7) > 2;
        else rsp_ch.ready <= $urandom_range(0, 3) != 0;
    end

    always @(posedge i_clk) if (cycle_count % 500 == 0) rsp_stall_mode <= ~rsp_stall_mode;

    int burst_left;

    task automatic send_request(tqs_pkg::t_op op, logic [tqs_pkg::HANDLE_W-1:0] handle = '0,
                                logic [tqs_pkg::DELAY_W-1:0] delay = '0, bit rpt = 1'b0,
                                logic [tqs_pkg::ID_W-1:0] target = '0);
        int gap;
        // let valid fall before the next request is driven
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.owner_handle <= handle;
        req_ch.delay_ticks  <= delay;
        req_ch.repeating    <= rpt;
        req_ch.target_id    <= target;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_request(op, handle, delay, rpt, target);
        requests_sent++;
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic test_extremes();
        send_request(tqs_pkg::OP_SCHEDULE, 16'hFFFF, 32'd0, 1'b0);
        send_request(tqs_pkg::OP_SCHEDULE, 16'h0000, 32'hFFFF_FFFF, 1'b1);
        send_request(tqs_pkg::OP_SCHEDULE, 16'h1234, 32'd1, 1'b1);
        send_request(tqs_pkg::OP_SCHEDULE, 16'h5555, 32'd0, 1'b1);  // interval zero repeats
        send_request(tqs_pkg::OP_TICK);
        send_request(tqs_pkg::OP_TICK);
        send_request(tqs_pkg::OP_CANCEL, '0, '0, 1'b0, 31'h7FFF_FFFF);
        send_request(tqs_pkg::OP_CANCEL, '0, '0, 1'b0, 31'd3);
        send_request(tqs_pkg::OP_CANCEL, '0, '0, 1'b0, 31'd2);
        send_request(tqs_pkg::OP_TICK);
    endtask

    task automatic test_full_and_ties();
        // fill the file with equal deadlines; the overflow is refused
        for (int i = 0; i < tqs_pkg::MAX_TIMERS + 2; i++)
            send_request(tqs_pkg::OP_SCHEDULE, 16'(i), 32'd2, 1'b0);
        send_request(tqs_pkg::OP_TICK);
        send_request(tqs_pkg::OP_TICK);
        send_request(tqs_pkg::OP_TICK);
        wait_drained();
    endtask

    task automatic test_random();
        int pick;
        int n;
        n = 0;
        while (n < 100 || expired_seen < 40) begin
            if (n > 400) break;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_request(tqs_pkg::OP_SCHEDULE, 16'($urandom),
                             $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 6),
                             $urandom_range(0, 1));
            else if (pick < 52)
                send_request(tqs_pkg::OP_CANCEL, '0, '0, 1'b0,
                             $urandom_range(0, 1) ? 31'($urandom) :
                             (next_id - 31'($urandom_range(1, 8))));
            else
                send_request(tqs_pkg::OP_TICK);
            n++;
            if (n == 50) wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_stop();
        send_request(tqs_pkg::OP_SCHEDULE, 16'hABCD, 32'd1, 1'b1);
        send_request(tqs_pkg::OP_STOP);
        repeat (40) @(negedge i_clk);
        send_request(tqs_pkg::OP_SCHEDULE, 16'h1111, 32'd1, 1'b0);
        send_request(tqs_pkg::OP_CANCEL, '0, '0, 1'b0, 31'd0);
        send_request(tqs_pkg::OP_TICK);
        send_request(tqs_pkg::OP_TICK);
    endtask

    initial begin
        cycle_count = 0;
        mismatches = 0;
        results_seen = 0;
        expired_seen = 0;
        requests_sent = 0;
        burst_left = 0;
        rsp_stall_mode = 1'b0;
        for (int i = 0; i < tqs_pkg::MAX_TIMERS; i++) tm_valid[i] = 1'b0;
        now_ticks = '0;
        next_id = '0;
        running = 1'b1;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = tqs_pkg::OP_TICK;
        req_ch.owner_handle = '0;
        req_ch.delay_ticks = '0;
        req_ch.repeating = 1'b0;
        req_ch.target_id = '0;
        rsp_ch.ready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_full_and_ties();
        test_random();
        test_stop();
        wait_drained();
        if (pending_results.size() != 0) mismatches = mismatches + pending_results.size();

        $display("Sent %0d requests, checked %0d results (%0d expirations)",
                 requests_sent, results_seen, expired_seen);
        $display("Covered schedule, cancel, tick ordering, full file, repeats and stop.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/tqs_pkg.sv
src/tqs_if.sv
src/tqs_cell.sv
src/timer_queue_scheduler.sv
tb/tb_top.sv
